### hw/rtl/spv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_pkg: shared types and constants of the sample playback voice
// Item kinds, register indexes, store geometry and the fixed-point format
// of the play position.
// ----------------------------------------------------------------------------
package spv_pkg;

  localparam int SAMPLE_DEPTH = 1048576;
  localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
  localparam int FRAC_BITS    = 12;
  // sign bit, integer part up to the full region length, fraction
  localparam int POS_W        = ADDR_W + 1 + FRAC_BITS;
  localparam int LEN_W        = ADDR_W + 1;
  localparam int STEP_W       = 16;
  localparam int SMP_W        = 16;
  localparam int CHAN_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = LEN_W;

  localparam logic [1:0] KIND_LOAD     = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd2;
  localparam logic [1:0] KIND_TICK     = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_START   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP    = 3'd5;

  // 1.0 in the position format
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(1 << FRAC_BITS);

  typedef struct packed {
    logic [ADDR_W-1:0] start_index;
    logic [LEN_W-1:0]  end_index;
    logic [STEP_W-1:0] step_rate;
    logic              play_forward;
    logic              loop_enable;
    logic              stop_on_release;
  } spv_cfg_t;

  typedef struct packed {
    logic add_en;   // voice sample joins the mix
    logic active;   // voice still playing after this item
  } spv_tick_t;

endpackage

### hw/rtl/spv_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when the
// read enable is low.
// ----------------------------------------------------------------------------
module spv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/spv_phase.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_phase: voice state and phase accumulator
// Holds gate, playing flag and the fixed-point play position; works out the
// store read address and the next state for each accepted item.
// ----------------------------------------------------------------------------
module spv_phase
  import spv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic [1:0]        kind_i,
  input  logic [CHAN_W-1:0] channel_i,
  input  spv_cfg_t          cfg_i,
  output logic [ADDR_W-1:0] rd_addr_o,
  output spv_tick_t         tick_o
);

  logic signed [POS_W-1:0] pos_q, pos_d;
  logic                    playing_q, playing_d;
  logic                    gate_q, gate_d;

  logic [LEN_W-1:0]   len;
  logic [LEN_W-1:0]   len_m1;
  logic [POS_W-1:0]   pos_last;
  logic [POS_W:0]     lenq;
  logic [ADDR_W-1:0]  ipos;
  logic [POS_W:0]     pos_fwd;
  logic [POS_W:0]     pos_rev;
  logic               in_range;
  logic               wrap;
  logic               chan0;

  assign len    = (cfg_i.end_index > {1'b0, cfg_i.start_index})
                ? cfg_i.end_index - {1'b0, cfg_i.start_index} : '0;
  assign len_m1 = len - LEN_W'(1);
  // integer position of the last sample in the region
  assign pos_last = {1'b0, len_m1[ADDR_W-1:0], {FRAC_BITS{1'b0}}};
  assign lenq     = {1'b0, len, {FRAC_BITS{1'b0}}};

  assign ipos      = pos_q[POS_W-2:FRAC_BITS];
  assign in_range  = !pos_q[POS_W-1] && ({1'b0, ipos} < len);
  assign rd_addr_o = cfg_i.start_index + ipos;
  assign wrap      = cfg_i.loop_enable && gate_q;
  assign chan0     = (channel_i == '0);

  assign pos_fwd = {2'b00, pos_q[POS_W-2:0]} + (POS_W+1)'(cfg_i.step_rate);
  assign pos_rev = {2'b00, pos_q[POS_W-2:0]} - (POS_W+1)'(cfg_i.step_rate);

  always_comb begin
    pos_d         = pos_q;
    playing_d     = playing_q;
    gate_d        = gate_q;
    tick_o.add_en = 1'b0;
    if (item_valid_i) begin
      case (kind_i)
        KIND_NOTE_ON: begin
          if (chan0) begin
            gate_d = 1'b1;
            if (cfg_i.play_forward) begin
              pos_d     = '0;
              playing_d = 1'b1;
            end else if (len != '0) begin
              pos_d     = pos_last;
              playing_d = 1'b1;
            end else begin
              playing_d = 1'b0;
            end
          end
        end
        KIND_NOTE_OFF: begin
          if (chan0) begin
            gate_d = 1'b0;
            if (cfg_i.stop_on_release) begin
              playing_d = 1'b0;
            end
          end
        end
        KIND_TICK: begin
          if (playing_q && (cfg_i.step_rate != '0)) begin
            if (!in_range) begin
              playing_d = 1'b0;
            end else begin
              tick_o.add_en = 1'b1;
              if (cfg_i.play_forward) begin
                pos_d = pos_fwd[POS_W-1:0];
                if (pos_fwd >= lenq) begin
                  if (wrap) begin
                    pos_d = '0;
                  end else begin
                    playing_d = 1'b0;
                  end
                end
              end else begin
                pos_d = pos_rev[POS_W-1:0];
                if (pos_rev[POS_W]) begin
                  if (wrap) begin
                    pos_d = pos_last;
                  end else begin
                    playing_d = 1'b0;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    tick_o.active = playing_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      playing_q <= 1'b0;
      gate_q    <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      playing_q <= playing_d;
      gate_q    <= gate_d;
    end
  end

endmodule

### hw/rtl/sample_playback_voice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_playback_voice: single-voice sample player
// Sample store, phase accumulator and saturating mix over a two-stage path.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      tuser kind, tdata fields
//   m_axis    out        m_axis_tvalid/tready      tdata mix_out, voice_active
//   cfg       in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle while the output is not stalled. A tick's result passes
// the read stage and the output register on its way to m_axis: the accepting
// edge registers the sample store read, and the output register then takes the
// added and saturated mix. Load and note items give no result. Reset clears
// voice state, configuration and valid flags; the store is not cleared. A
// stalled output holds the read stage, and input is taken again as soon as the read stage can move on.
// ----------------------------------------------------------------------------
module sample_playback_voice
  import spv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [3:0] channel, [23:4] load_address, [39:24] load_sample, [55:40] mix_in
  input  logic [55:0]           s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] mix_out, [16] voice_active, [23:17] zero
  output logic [23:0]           m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  spv_cfg_t cfg_q;

  logic              in_acc;
  logic [CHAN_W-1:0] in_chan;
  logic [ADDR_W-1:0] in_addr;
  logic [SMP_W-1:0]  in_smp;
  logic [SMP_W-1:0]  in_mix;
  logic              is_tick;
  logic [ADDR_W-1:0] rd_addr;
  spv_tick_t         tick;
  logic [SMP_W-1:0]  rdata;

  logic              s1_valid_q;
  logic [SMP_W-1:0]  s1_mix_q;
  spv_tick_t         s1_tick_q;
  logic              s1_adv;

  logic              out_valid_q;
  logic [SMP_W-1:0]  out_mix_q, out_mix_d;
  logic              out_active_q;
  logic signed [SMP_W:0] sum;

  assign in_chan = s_axis_tdata[3:0];
  assign in_addr = s_axis_tdata[23:4];
  assign in_smp  = s_axis_tdata[39:24];
  assign in_mix  = s_axis_tdata[55:40];

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_index     <= '0;
      cfg_q.end_index       <= '0;
      cfg_q.step_rate       <= STEP_RESET;
      cfg_q.play_forward    <= 1'b1;
      cfg_q.loop_enable     <= 1'b0;
      cfg_q.stop_on_release <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_START:   cfg_q.start_index     <= cfg_data_i[ADDR_W-1:0];
        CFG_END:     cfg_q.end_index       <= cfg_data_i[LEN_W-1:0];
        CFG_STEP:    cfg_q.step_rate       <= cfg_data_i[STEP_W-1:0];
        CFG_FORWARD: cfg_q.play_forward    <= cfg_data_i[0];
        CFG_LOOP:    cfg_q.loop_enable     <= cfg_data_i[0];
        CFG_STOP:    cfg_q.stop_on_release <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: output register, then the read stage
  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_tick       = (s_axis_tuser == KIND_TICK);

  spv_phase u_phase (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_acc),
    .kind_i       (s_axis_tuser),
    .channel_i    (in_chan),
    .cfg_i        (cfg_q),
    .rd_addr_o    (rd_addr),
    .tick_o       (tick)
  );

  spv_ram #(
    .WIDTH (SMP_W),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && (s_axis_tuser == KIND_LOAD)),
    .waddr_i (in_addr),
    .wdata_i (in_smp),
    .re_i    (in_acc && is_tick),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= in_acc && is_tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_tick) begin
      s1_mix_q  <= in_mix;
      s1_tick_q <= tick;
    end
  end

  // mix and saturate
  always_comb begin
    sum = {s1_mix_q[SMP_W-1], s1_mix_q};
    if (s1_tick_q.add_en) begin
      sum = sum + {rdata[SMP_W-1], rdata};
    end
    if (sum[SMP_W] != sum[SMP_W-1]) begin
      out_mix_d = {sum[SMP_W], {(SMP_W-1){~sum[SMP_W]}}};
    end else begin
      out_mix_d = sum[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_mix_q    <= out_mix_d;
      out_active_q <= s1_tick_q.active;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_active_q, out_mix_q};

endmodule
